@@ design/assert_macros.svh @@
// Assertion macros shared by the scheduler modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every clock edge outside reset.
`define SJF_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Check on every clock edge, reset included.
`define SJF_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ design/sjf_pkg.sv @@
// Shared constants, types and helpers of the shortest-job-first scheduler.
package sjf_pkg;

	localparam int MAX_JOBS = 16;
	localparam int SLOT_W   = $clog2(MAX_JOBS);
	localparam int CNT_W    = $clog2(MAX_JOBS + 1);
	localparam int TIME_W   = 24;
	localparam int ARR_W    = 16;
	localparam int BURST_W  = 16;
	localparam int KIND_W   = 3;
	localparam int ENTRY_W  = ARR_W + 2 * BURST_W;

	localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

	// Event codes of a result word
	typedef enum logic [KIND_W-1:0] {
		EV_LOAD_OK    = 3'd0,
		EV_TABLE_FULL = 3'd1,
		EV_RUNNING    = 3'd2,
		EV_TERMINATED = 3'd3,
		EV_STARTED    = 3'd4,
		EV_ALL_DONE   = 3'd5
	} event_kind_t;

	// Input command codes
	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_TICK = 1'b1;

	// Controller to datapath commands
	typedef struct packed {
		logic cap_in;
		logic do_load;
		logic upd_busy;
		logic scan_init;
		logic scan_step;
		logic start_job;
		logic emit_done;
	} dp_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic out_free;
		logic busy;
		logic pend_nz;
		logic pend_one;
		logic term;
		logic scan_last;
	} dp_stat_t;

	// Difference clamped at zero
	function automatic logic [TIME_W-1:0] sub_clamp(input logic [TIME_W-1:0] a,
		input logic [TIME_W-1:0] b);
		sub_clamp = (a > b) ? (a - b) : '0;
	endfunction

endpackage

@@ design/sjf_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module sjf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

@@ design/sjf_ctrl.sv @@
// Controller state machine of the scheduler: sequences loads, ticks and scans.
module sjf_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic             cmd,
	output logic             in_ready,
	input  sjf_pkg::dp_stat_t stat,
	output sjf_pkg::dp_cmd_t  dcmd
);
	import sjf_pkg::*;

	`include "assert_macros.svh"

	typedef enum logic [7:0] {
		S_IDLE     = 8'b0000_0001,
		S_LOAD     = 8'b0000_0010,
		S_RD       = 8'b0000_0100,
		S_UPD      = 8'b0000_1000,
		S_SCAN     = 8'b0001_0000,
		S_SCAN_END = 8'b0010_0000,
		S_START    = 8'b0100_0000,
		S_DONE     = 8'b1000_0000
	} state_t;

	state_t state_q, state_d;

	assign in_ready = (state_q == S_IDLE);

	// Next state and datapath commands
	always_comb begin
		state_d = state_q;
		dcmd    = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					dcmd.cap_in = 1'b1;
					state_d = (cmd == CMD_TICK) ? S_RD : S_LOAD;
				end
			end
			S_LOAD: begin
				if (stat.out_free) begin
					dcmd.do_load = 1'b1;
					state_d = S_IDLE;
				end
			end
			S_RD: begin
				if (stat.busy) begin
					state_d = S_UPD;
				end else if (!stat.pend_nz) begin
					state_d = S_DONE;
				end else begin
					dcmd.scan_init = 1'b1;
					state_d = S_SCAN;
				end
			end
			S_UPD: begin
				if (stat.out_free) begin
					dcmd.upd_busy = 1'b1;
					if (!stat.term) begin
						state_d = S_IDLE;
					end else if (stat.pend_one) begin
						state_d = S_DONE;
					end else begin
						dcmd.scan_init = 1'b1;
						state_d = S_SCAN;
					end
				end
			end
			S_SCAN: begin
				dcmd.scan_step = 1'b1;
				if (stat.scan_last) begin
					state_d = S_SCAN_END;
				end
			end
			S_SCAN_END: begin
				state_d = S_START;
			end
			S_START: begin
				if (stat.out_free) begin
					dcmd.start_job = 1'b1;
					state_d = S_IDLE;
				end
			end
			S_DONE: begin
				if (stat.out_free) begin
					dcmd.emit_done = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	`SJF_ASSERT(a_scan_end_after_scan, (state_q == S_SCAN_END) |-> ($past(state_q) == S_SCAN), "scan end not preceded by scan")
	`SJF_ASSERT(a_start_after_scan, (state_q == S_START) |-> ($past(state_q) == S_SCAN_END || $past(state_q) == S_START), "start without a finished scan")
	`SJF_ASSERT(a_scan_needs_pending, (state_q == S_SCAN) |-> stat.pend_nz, "scan with no pending job")

endmodule

@@ design/sjf_dp.sv @@
// Datapath of the scheduler: job table, time, scan trackers and result word.
module sjf_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  sjf_pkg::dp_cmd_t              dcmd,
	output sjf_pkg::dp_stat_t             stat,
	input  logic                          cmd,
	input  logic [sjf_pkg::ARR_W-1:0]     arrival_time,
	input  logic [sjf_pkg::BURST_W-1:0]   burst_time,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [sjf_pkg::KIND_W-1:0]    event_kind,
	output logic [sjf_pkg::SLOT_W-1:0]    job_slot,
	output logic [sjf_pkg::TIME_W-1:0]    current_time,
	output logic [sjf_pkg::BURST_W-1:0]   remaining_burst,
	output logic [sjf_pkg::TIME_W-1:0]    completion_time,
	output logic [sjf_pkg::TIME_W-1:0]    turnaround_time,
	output logic [sjf_pkg::TIME_W-1:0]    waiting_time,
	output logic [sjf_pkg::TIME_W-1:0]    response_time,
	output logic                          last_result
);
	import sjf_pkg::*;

	`include "assert_macros.svh"

	// Control state
	logic [CNT_W-1:0]  count_q, pend_q;
	logic [TIME_W-1:0] time_q;
	logic              busy_q;
	logic [SLOT_W-1:0] busy_slot_q;
	logic [SLOT_W-1:0] idx_q;
	logic              rd_vld_s1;
	logic [SLOT_W-1:0] idx_s1;
	logic              out_valid_q;

	// Captured input payload
	logic [ARR_W-1:0]   at_q;
	logic [BURST_W-1:0] bt_q;

	// Scan trackers: best arrived job and earliest pending job
	logic               a_found_q, e_found_q;
	logic [SLOT_W-1:0]  a_slot_q, e_slot_q;
	logic [BURST_W-1:0] a_left_q, e_left_q;
	logic [ARR_W-1:0]   a_arr_q, e_arr_q;

	// Result word
	event_kind_t        kind_q;
	logic [SLOT_W-1:0]  slot_q;
	logic [TIME_W-1:0]  ctime_q, comp_q, tat_q, wt_q, rt_q;
	logic [BURST_W-1:0] rem_q;
	logic               last_q;

	// Table port
	logic               we;
	logic [SLOT_W-1:0]  waddr, raddr;
	logic [ENTRY_W-1:0] wdata, rdata;
	logic [ARR_W-1:0]   rd_arr;
	logic [BURST_W-1:0] rd_total, rd_left, new_left;
	logic [TIME_W-1:0]  tat, wt;
	logic               full, out_free, cand, a_take, e_take;
	logic               sel_a;
	logic [SLOT_W-1:0]  pick_slot;
	logic [BURST_W-1:0] pick_left;
	logic [TIME_W-1:0]  pick_time, pick_rt;

	assign rd_arr   = rdata[ENTRY_W-1 -: ARR_W];
	assign rd_total = rdata[2*BURST_W-1 -: BURST_W];
	assign rd_left  = rdata[BURST_W-1:0];
	assign new_left = rd_left - 1'b1;
	assign tat      = sub_clamp(time_q, TIME_W'(rd_arr));
	assign wt       = sub_clamp(tat, TIME_W'(rd_total));
	assign full     = (count_q == CNT_W'(MAX_JOBS));
	assign out_free = !out_valid_q || out_ready;

	// Pick the table address for each access
	always_comb begin
		we    = 1'b0;
		waddr = busy_slot_q;
		wdata = {rd_arr, rd_total, new_left};
		if (dcmd.do_load && !full) begin
			we    = 1'b1;
			waddr = count_q[SLOT_W-1:0];
			wdata = {at_q, bt_q, bt_q};
		end else if (dcmd.upd_busy) begin
			we = 1'b1;
		end
	end
	assign raddr = dcmd.scan_step ? idx_q : busy_slot_q;

	sjf_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(MAX_JOBS)
	) u_table (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	// Compare scanned entry against both trackers
	assign cand   = rd_vld_s1 && (rd_left != '0);
	assign a_take = cand && (TIME_W'(rd_arr) <= time_q) && (!a_found_q || rd_left < a_left_q);
	assign e_take = cand && (!e_found_q || rd_arr < e_arr_q ||
		(rd_arr == e_arr_q && rd_left < e_left_q));

	// Chosen job at start
	assign sel_a     = a_found_q;
	assign pick_slot = sel_a ? a_slot_q : e_slot_q;
	assign pick_left = sel_a ? a_left_q : e_left_q;
	assign pick_time = sel_a ? time_q : TIME_W'(e_arr_q);
	assign pick_rt   = sel_a ? sub_clamp(time_q, TIME_W'(a_arr_q)) : '0;

	// Capture input payload
	always_ff @(posedge clk) begin
		if (dcmd.cap_in) begin
			at_q <= arrival_time;
			bt_q <= burst_time;
		end
	end

	// Scheduler state: count, pending jobs, time, running job
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			pend_q      <= '0;
			time_q      <= '0;
			busy_q      <= 1'b0;
			busy_slot_q <= '0;
		end else begin
			if (dcmd.cap_in && cmd == CMD_TICK && time_q != TIME_MAX) begin
				time_q <= time_q + 1'b1;
			end
			if (dcmd.do_load && !full) begin
				count_q <= count_q + 1'b1;
				if (bt_q != '0) begin
					pend_q <= pend_q + 1'b1;
				end
			end
			if (dcmd.upd_busy && rd_left == BURST_W'(1)) begin
				pend_q <= pend_q - 1'b1;
				busy_q <= 1'b0;
			end
			if (dcmd.start_job) begin
				busy_q      <= 1'b1;
				busy_slot_q <= pick_slot;
				time_q      <= pick_time;
			end
		end
	end

	// Scan address counter, read tag and tracker found flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q     <= '0;
			rd_vld_s1 <= 1'b0;
			a_found_q <= 1'b0;
			e_found_q <= 1'b0;
		end else begin
			rd_vld_s1 <= dcmd.scan_step;
			if (dcmd.scan_init) begin
				idx_q     <= '0;
				a_found_q <= 1'b0;
				e_found_q <= 1'b0;
			end else begin
				if (dcmd.scan_step) begin
					idx_q <= idx_q + 1'b1;
				end
				if (a_take) begin
					a_found_q <= 1'b1;
				end
				if (e_take) begin
					e_found_q <= 1'b1;
				end
			end
		end
	end

	// Tracker payload
	always_ff @(posedge clk) begin
		idx_s1 <= idx_q;
		if (a_take) begin
			a_slot_q <= idx_s1;
			a_left_q <= rd_left;
			a_arr_q  <= rd_arr;
		end
		if (e_take) begin
			e_slot_q <= idx_s1;
			e_left_q <= rd_left;
			e_arr_q  <= rd_arr;
		end
	end

	// Output word valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (dcmd.do_load || dcmd.upd_busy || dcmd.start_job || dcmd.emit_done) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Build the output word
	always_ff @(posedge clk) begin
		if (dcmd.do_load || dcmd.upd_busy || dcmd.start_job || dcmd.emit_done) begin
			kind_q  <= EV_ALL_DONE;
			slot_q  <= '0;
			ctime_q <= time_q;
			rem_q   <= '0;
			comp_q  <= '0;
			tat_q   <= '0;
			wt_q    <= '0;
			rt_q    <= '0;
			last_q  <= 1'b1;
			if (dcmd.do_load) begin
				if (full) begin
					kind_q <= EV_TABLE_FULL;
				end else begin
					kind_q <= EV_LOAD_OK;
					slot_q <= count_q[SLOT_W-1:0];
					rem_q  <= bt_q;
				end
			end else if (dcmd.upd_busy) begin
				slot_q <= busy_slot_q;
				if (rd_left == BURST_W'(1)) begin
					kind_q <= EV_TERMINATED;
					comp_q <= time_q;
					tat_q  <= tat;
					wt_q   <= wt;
					last_q <= 1'b0;
				end else begin
					kind_q <= EV_RUNNING;
					rem_q  <= new_left;
				end
			end else if (dcmd.start_job) begin
				kind_q  <= EV_STARTED;
				slot_q  <= pick_slot;
				rem_q   <= pick_left;
				ctime_q <= pick_time;
				rt_q    <= pick_rt;
			end
		end
	end

	assign stat.out_free  = out_free;
	assign stat.busy      = busy_q;
	assign stat.pend_nz   = (pend_q != '0);
	assign stat.pend_one  = (pend_q == CNT_W'(1));
	assign stat.term      = (rd_left == BURST_W'(1));
	assign stat.scan_last = (CNT_W'(idx_q) == count_q - 1'b1);

	assign out_valid       = out_valid_q;
	assign event_kind      = kind_q;
	assign job_slot        = slot_q;
	assign current_time    = ctime_q;
	assign remaining_burst = rem_q;
	assign completion_time = comp_q;
	assign turnaround_time = tat_q;
	assign waiting_time    = wt_q;
	assign response_time   = rt_q;
	assign last_result     = last_q;

	`SJF_ASSERT_ALWAYS(a_busy_has_pending, busy_q |-> (pend_q != '0), "running job but no pending job")
	`SJF_ASSERT_ALWAYS(a_pend_le_count, pend_q <= count_q, "more pending jobs than loaded")
	`SJF_ASSERT(a_term_clears_busy, (dcmd.upd_busy && rd_left == BURST_W'(1)) |=> !busy_q, "terminated job still marked running")
	`SJF_ASSERT(a_start_has_pick, dcmd.start_job |-> (a_found_q || e_found_q), "start without a candidate")

endmodule

@@ design/nonpreemptive_sjf_scheduler_top.sv @@
// Flow: a load is captured, then written to the table and its result registered once the output word is free;
// a tick on a running job is captured, the job's entry read, then updated and its result registered. A tick that
// starts a job scans the table through one read port, after an update step when the running job ends on that tick.
// One item is worked at a time; the next is taken as soon as the last result is in the output register.
// Reset (arst_n low, asynchronous) empties the table, clears time and leaves no job running.
module nonpreemptive_sjf_scheduler_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          cmd,
	input  logic [sjf_pkg::ARR_W-1:0]     arrival_time,
	input  logic [sjf_pkg::BURST_W-1:0]   burst_time,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [sjf_pkg::KIND_W-1:0]    event_kind,
	output logic [sjf_pkg::SLOT_W-1:0]    job_slot,
	output logic [sjf_pkg::TIME_W-1:0]    current_time,
	output logic [sjf_pkg::BURST_W-1:0]   remaining_burst,
	output logic [sjf_pkg::TIME_W-1:0]    completion_time,
	output logic [sjf_pkg::TIME_W-1:0]    turnaround_time,
	output logic [sjf_pkg::TIME_W-1:0]    waiting_time,
	output logic [sjf_pkg::TIME_W-1:0]    response_time,
	output logic                          last_result
);
	import sjf_pkg::*;

	dp_cmd_t  dcmd;
	dp_stat_t stat;

	// Sequence each word
	sjf_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.cmd     (cmd),
		.in_ready(in_ready),
		.stat    (stat),
		.dcmd    (dcmd)
	);

	// Table, time and result word
	sjf_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.dcmd           (dcmd),
		.stat           (stat),
		.cmd            (cmd),
		.arrival_time   (arrival_time),
		.burst_time     (burst_time),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.event_kind     (event_kind),
		.job_slot       (job_slot),
		.current_time   (current_time),
		.remaining_burst(remaining_burst),
		.completion_time(completion_time),
		.turnaround_time(turnaround_time),
		.waiting_time   (waiting_time),
		.response_time  (response_time),
		.last_result    (last_result)
	);

endmodule

@@ bench/tb.sv @@
// Testbench for the non-preemptive shortest-job-first scheduler: directed and random words.
module tb;
	import sjf_pkg::*;

	// One scheduler event as seen on the result port
	typedef struct {
		event_kind_t           kind;
		logic [SLOT_W-1:0]     slot;
		logic [TIME_W-1:0]     cur;
		logic [BURST_W-1:0]    rem;
		logic [TIME_W-1:0]     done_at;
		logic [TIME_W-1:0]     tat;
		logic [TIME_W-1:0]     wait_t;
		logic [TIME_W-1:0]     resp;
		logic                  last;
	} sched_event_t;

	logic                  clk;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_ready;
	logic                  cmd;
	logic [ARR_W-1:0]      arrival_time;
	logic [BURST_W-1:0]    burst_time;
	logic                  out_valid;
	logic                  out_ready;
	logic [KIND_W-1:0]     event_kind;
	logic [SLOT_W-1:0]     job_slot;
	logic [TIME_W-1:0]     current_time;
	logic [BURST_W-1:0]    remaining_burst;
	logic [TIME_W-1:0]     completion_time;
	logic [TIME_W-1:0]     turnaround_time;
	logic [TIME_W-1:0]     waiting_time;
	logic [TIME_W-1:0]     response_time;
	logic                  last_result;

	// Scheduler state mirrored by the bench
	logic [ARR_W-1:0]      job_arr   [MAX_JOBS];
	logic [BURST_W-1:0]    job_total [MAX_JOBS];
	logic [BURST_W-1:0]    job_left  [MAX_JOBS];
	int                    job_cnt;
	logic [TIME_W-1:0]     job_now;
	bit                    run_flag;
	int                    run_slot;

	sched_event_t          sched_events[$];
	int                    fail_count;
	int                    sender_run_left;

	nonpreemptive_sjf_scheduler_top i_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.cmd             (cmd),
		.arrival_time    (arrival_time),
		.burst_time      (burst_time),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.event_kind      (event_kind),
		.job_slot        (job_slot),
		.current_time    (current_time),
		.remaining_burst (remaining_burst),
		.completion_time (completion_time),
		.turnaround_time (turnaround_time),
		.waiting_time    (waiting_time),
		.response_time   (response_time),
		.last_result     (last_result)
	);

	// Clock
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Hard limit on the run
	initial begin
		#10_000_000;
		$display("Regression FAIL");
		$finish;
	end

	// Difference clamped at zero
	function automatic logic [TIME_W-1:0] floor_sub(input logic [TIME_W-1:0] a,
		input logic [TIME_W-1:0] b);
		return (a > b) ? (a - b) : '0;
	endfunction

	function automatic sched_event_t make_event(input event_kind_t kind, input int slot,
		input logic [BURST_W-1:0] rem, input logic [TIME_W-1:0] done_at,
		input logic [TIME_W-1:0] tat, input logic [TIME_W-1:0] wait_t,
		input logic [TIME_W-1:0] resp);
		sched_event_t e;
		e.kind    = kind;
		e.slot    = SLOT_W'(slot);
		e.cur     = job_now;
		e.rem     = rem;
		e.done_at = done_at;
		e.tat     = tat;
		e.wait_t  = wait_t;
		e.resp    = resp;
		e.last    = 1'b0;
		return e;
	endfunction

	// Advance the mirrored scheduler by one accepted word and queue its events
	task automatic step_scheduler(input logic c, input logic [ARR_W-1:0] arr,
		input logic [BURST_W-1:0] bst);
		sched_event_t ev[2];
		int n;
		int pick;
		bit found;
		bit pending;
		logic [TIME_W-1:0] tat;
		n = 0;
		pick = 0;
		found = 1'b0;
		pending = 1'b0;
		if (c == CMD_LOAD) begin
			if (job_cnt < MAX_JOBS) begin
				job_arr[job_cnt]   = arr;
				job_total[job_cnt] = bst;
				job_left[job_cnt]  = bst;
				ev[0] = make_event(EV_LOAD_OK, job_cnt, bst, '0, '0, '0, '0);
				job_cnt++;
			end else begin
				ev[0] = make_event(EV_TABLE_FULL, 0, '0, '0, '0, '0, '0);
			end
			n = 1;
		end else begin
			if (job_now != TIME_MAX)
				job_now = job_now + 1'b1;
			// Count down the running job
			if (run_flag && run_slot < job_cnt) begin
				if (job_left[run_slot] != 0)
					job_left[run_slot] = job_left[run_slot] - 1'b1;
				if (job_left[run_slot] != 0) begin
					ev[n] = make_event(EV_RUNNING, run_slot, job_left[run_slot], '0, '0, '0,
						'0);
				end else begin
					tat = floor_sub(job_now, job_arr[run_slot]);
					ev[n] = make_event(EV_TERMINATED, run_slot, '0, job_now, tat,
						floor_sub(tat, job_total[run_slot]), '0);
					run_flag = 1'b0;
				end
				n++;
			end else begin
				run_flag = 1'b0;
			end
			for (int i = 0; i < job_cnt; i++)
				if (job_left[i] != 0)
					pending = 1'b1;
			if (!pending) begin
				ev[n] = make_event(EV_ALL_DONE, 0, '0, '0, '0, '0, '0);
				n++;
			end else if (!run_flag) begin
				// Shortest remaining burst among arrived jobs, ties to the lowest slot
				for (int i = 0; i < job_cnt; i++) begin
					if (job_left[i] != 0 && TIME_W'(job_arr[i]) <= job_now &&
						(!found || job_left[i] < job_left[pick])) begin
						pick = i;
						found = 1'b1;
					end
				end
				// Nothing arrived: jump to the earliest pending arrival
				if (!found) begin
					for (int i = 0; i < job_cnt; i++) begin
						if (job_left[i] != 0 && (!found || job_arr[i] < job_arr[pick] ||
							(job_arr[i] == job_arr[pick] &&
							job_left[i] < job_left[pick]))) begin
							pick = i;
							found = 1'b1;
						end
					end
					job_now = TIME_W'(job_arr[pick]);
				end
				run_flag = 1'b1;
				run_slot = pick;
				ev[n] = make_event(EV_STARTED, pick, job_left[pick], '0, '0, '0,
					floor_sub(job_now, job_arr[pick]));
				n++;
			end
		end
		ev[n-1].last = 1'b1;
		for (int i = 0; i < n; i++)
			sched_events.push_back(ev[i]);
	endtask

	// Send one word, idling between bursts, and predict it once accepted
	task automatic send_word(input logic c, input logic [ARR_W-1:0] arr,
		input logic [BURST_W-1:0] bst);
		int gap;
		if (sender_run_left == 0) begin
			gap = $urandom_range(1, 8);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
			sender_run_left = ($urandom_range(0, 7) == 0) ? 120 : $urandom_range(1, 16);
		end
		sender_run_left--;
		in_valid     <= 1'b1;
		cmd          <= c;
		arrival_time <= arr;
		burst_time   <= bst;
		do @(posedge clk); while (!in_ready);
		step_scheduler(c, arr, bst);
	endtask

	task automatic send_tick();
		send_word(CMD_TICK, ARR_W'($urandom), BURST_W'($urandom));
	endtask

	// Hold the sender until every queued event has come out
	task automatic wait_drained();
		in_valid <= 1'b0;
		while (sched_events.size() != 0) @(posedge clk);
	endtask

	function automatic logic [ARR_W-1:0] near_arrival(input int unsigned spread);
		int unsigned t;
		t = job_now + $urandom_range(0, spread);
		return (t > 65535) ? ARR_W'(65535) : ARR_W'(t);
	endfunction

	// Ticks on an empty table
	task automatic test_empty_table();
		send_tick();
		send_tick();
	endtask

	// Zero bursts, equal bursts, a jump to a late arrival, a load after all done
	task automatic test_scheduling();
		send_word(CMD_LOAD, 16'd0, 16'd0);
		send_word(CMD_LOAD, 16'hFFFF, 16'd0);
		send_tick();
		send_word(CMD_LOAD, 16'd0, 16'd4);
		send_word(CMD_LOAD, 16'd0, 16'd4);
		send_word(CMD_LOAD, 16'd100, 16'd2);
		send_word(CMD_LOAD, 16'd200, 16'd1);
		repeat (14) send_tick();
		send_word(CMD_LOAD, 16'd0, 16'd3);
		send_tick();
	endtask

	// Random loads spread over a long run of ticks, one slot kept free
	task automatic test_random_mix();
		logic [ARR_W-1:0] arr;
		logic [BURST_W-1:0] bst;
		repeat (1500) begin
			if (job_cnt < MAX_JOBS - 1 && $urandom_range(0, 119) == 0) begin
				if ($urandom_range(0, 2) == 0)
					arr = ARR_W'($urandom_range(0, (job_now > 65535) ? 65535 : job_now));
				else
					arr = near_arrival(300);
				case ($urandom_range(0, 19))
					0:       bst = '0;
					1, 2:    bst = 16'd5;
					3, 4:    bst = 16'd10;
					default: bst = BURST_W'($urandom_range(1, 150));
				endcase
				send_word(CMD_LOAD, arr, bst);
			end else begin
				send_tick();
			end
			if ($urandom_range(0, 299) == 0)
				wait_drained();
		end
	endtask

	// Fill the table, end with the longest job, then reject loads
	task automatic test_table_full();
		while (job_cnt < MAX_JOBS - 1)
			send_word(CMD_LOAD, near_arrival(100), BURST_W'($urandom_range(1, 40)));
		send_word(CMD_LOAD, 16'hFFFF, 16'hFFFF);
		send_word(CMD_LOAD, 16'hFFFF, 16'hFFFF);
		send_word(CMD_LOAD, 16'd0, 16'd0);
		repeat (40) begin
			if ($urandom_range(0, 1) == 0)
				send_word(CMD_LOAD, ARR_W'($urandom), BURST_W'($urandom));
			else
				send_tick();
		end
	endtask

	// Receiver: stall, then take words, on a pattern of its own
	initial begin
		int stall;
		int run;
		forever begin
			stall = $urandom_range(1, 8);
			run = ($urandom_range(0, 5) == 0) ? 150 : $urandom_range(1, 12);
			out_ready <= 1'b0;
			repeat (stall) @(posedge clk);
			out_ready <= 1'b1;
			repeat (run) @(posedge clk);
		end
	end

	task automatic check_field(input string name, input logic [31:0] want,
		input logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			fail_count++;
		end
	endtask

	// Compare each accepted result word with the oldest queued event
	initial begin
		sched_event_t e;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && out_ready) begin
				if (sched_events.size() == 0) begin
					$error("result word with no event queued: kind %0d slot %0d", event_kind,
						job_slot);
					fail_count++;
				end else begin
					e = sched_events.pop_front();
					check_field("event_kind", 32'(e.kind), 32'(event_kind));
					check_field("job_slot", 32'(e.slot), 32'(job_slot));
					check_field("current_time", 32'(e.cur), 32'(current_time));
					check_field("remaining_burst", 32'(e.rem), 32'(remaining_burst));
					check_field("completion_time", 32'(e.done_at), 32'(completion_time));
					check_field("turnaround_time", 32'(e.tat), 32'(turnaround_time));
					check_field("waiting_time", 32'(e.wait_t), 32'(waiting_time));
					check_field("response_time", 32'(e.resp), 32'(response_time));
					check_field("last_result", 32'(e.last), 32'(last_result));
				end
			end
		end
	end

	// Main sequence
	initial begin
		fail_count = 0;
		sender_run_left = 0;
		job_cnt = 0;
		job_now = '0;
		run_flag = 1'b0;
		run_slot = 0;
		arst_n       <= 1'b0;
		in_valid     <= 1'b0;
		cmd          <= CMD_LOAD;
		arrival_time <= '0;
		burst_time   <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_table();
		test_scheduling();
		wait_drained();
		test_random_mix();
		test_table_full();
		wait_drained();
		repeat (30) @(posedge clk);
		if (fail_count == 0 && sched_events.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

@@ files.f @@
+incdir+design
design/sjf_pkg.sv
design/sjf_ram.sv
design/sjf_ctrl.sv
design/sjf_dp.sv
design/nonpreemptive_sjf_scheduler_top.sv
bench/tb.sv
